/* rtl/dbrf_pkg.sv */
// shared types, widths and register codes for the detection box rescale filter
`default_nettype none

package dbrf_pkg;

  localparam int COORD_W         = 16;
  localparam int SCORE_W         = 16;
  localparam int CLASS_W         = 10;
  localparam int PIX_W           = 12;
  localparam int PAD_W           = 11;
  localparam int INV_W           = 16;
  localparam int COUNT_W         = 10;
  localparam int CFG_ADDR_W      = 5;
  localparam int CFG_DATA_W      = 32;
  localparam int MAX_KEPT        = 512;
  localparam int COORD_FRAC_BITS = 4;
  localparam int SCALE_FRAC_BITS = 12;
  localparam int PIX_SHIFT       = COORD_FRAC_BITS + SCALE_FRAC_BITS;
  localparam int DIFF_W          = COORD_W + 2;
  localparam int PROD_W          = DIFF_W + INV_W + 1;

  localparam logic [SCORE_W-1:0] SCORE_THRESHOLD_RST = 16'd16384;
  localparam logic [COUNT_W-1:0] DETECTION_LIMIT_RST = 10'd300;
  localparam logic [INV_W-1:0]   INVERSE_SCALE_RST   = 16'd4096;
  localparam logic [PIX_W-1:0]   IMAGE_WIDTH_RST     = 12'd640;
  localparam logic [PIX_W-1:0]   IMAGE_HEIGHT_RST    = 12'd480;

  typedef enum logic [2:0] {
    REG_SCORE_THRESHOLD = 3'd0,
    REG_DETECTION_LIMIT = 3'd1,
    REG_INVERSE_SCALE   = 3'd2,
    REG_PAD_LEFT        = 3'd3,
    REG_PAD_TOP         = 3'd4,
    REG_IMAGE_WIDTH     = 3'd5,
    REG_IMAGE_HEIGHT    = 3'd6
  } reg_idx_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [PIX_W-1:0]          pix_t;
  typedef logic [SCORE_W-1:0]        score_t;
  typedef logic [CLASS_W-1:0]        class_t;
  typedef logic [COUNT_W-1:0]        count_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

endpackage

`default_nettype wire

/* rtl/dbrf_if.sv */
// box input and box result channel interfaces
`default_nettype none

interface dbrf_in_if;
  import dbrf_pkg::*;
  logic   valid;
  logic   ready;
  coord_t raw_x1;
  coord_t raw_y1;
  coord_t raw_x2;
  coord_t raw_y2;
  score_t score_in;
  class_t class_in;
  logic   last_box;

  modport source (output valid, raw_x1, raw_y1, raw_x2, raw_y2, score_in, class_in,
                  last_box, input ready);
  modport sink (input valid, raw_x1, raw_y1, raw_x2, raw_y2, score_in, class_in,
                last_box, output ready);
endinterface

interface dbrf_out_if;
  import dbrf_pkg::*;
  logic   valid;
  logic   ready;
  logic   box_valid;
  pix_t   x_left;
  pix_t   y_top;
  pix_t   x_right;
  pix_t   y_bottom;
  score_t score_out;
  class_t class_out;
  logic   frame_done;
  count_t kept_total;

  modport source (output valid, box_valid, x_left, y_top, x_right, y_bottom, score_out,
                  class_out, frame_done, kept_total, input ready);
  modport sink (input valid, box_valid, x_left, y_top, x_right, y_bottom, score_out,
                class_out, frame_done, kept_total, output ready);
endinterface

`default_nettype wire

/* rtl/detection_box_rescale_filter.sv */
// letterbox box rescale, clip, score, zero-area and detection-limit filter and per-frame box count
// throughput: one item per cycle unless box_out holds ready low; stages are
// input register, product register (four 18x17 multiplies) and result
// register, each loads when the next one frees
// synchronous reset clears valid bits, the frame count and all config registers
// to their defaults; payload registers are not reset
`default_nettype none

module detection_box_rescale_filter (
  input  wire logic                             clk,
  input  wire logic                             rst,
  dbrf_in_if.sink                               box_in,
  dbrf_out_if.source                            box_out,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [dbrf_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [dbrf_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [dbrf_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                  pready
);
  import dbrf_pkg::*;

  // config registers
  score_t             score_threshold;
  count_t             detection_limit;
  logic [INV_W-1:0]   inverse_scale;
  logic [PAD_W-1:0]   pad_left;
  logic [PAD_W-1:0]   pad_top;
  pix_t               image_width;
  pix_t               image_height;

  reg_idx_t           cfg_idx;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign cfg_idx   = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      score_threshold <= SCORE_THRESHOLD_RST;
      detection_limit <= DETECTION_LIMIT_RST;
      inverse_scale   <= INVERSE_SCALE_RST;
      pad_left        <= '0;
      pad_top         <= '0;
      image_width     <= IMAGE_WIDTH_RST;
      image_height    <= IMAGE_HEIGHT_RST;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_SCORE_THRESHOLD: score_threshold <= pwdata[SCORE_W-1:0];
        REG_DETECTION_LIMIT: detection_limit <= pwdata[COUNT_W-1:0];
        REG_INVERSE_SCALE:   inverse_scale   <= pwdata[INV_W-1:0];
        REG_PAD_LEFT:        pad_left        <= pwdata[PAD_W-1:0];
        REG_PAD_TOP:         pad_top         <= pwdata[PAD_W-1:0];
        REG_IMAGE_WIDTH:     image_width     <= pwdata[PIX_W-1:0];
        REG_IMAGE_HEIGHT:    image_height    <= pwdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SCORE_THRESHOLD: prdata = CFG_DATA_W'(score_threshold);
      REG_DETECTION_LIMIT: prdata = CFG_DATA_W'(detection_limit);
      REG_INVERSE_SCALE:   prdata = CFG_DATA_W'(inverse_scale);
      REG_PAD_LEFT:        prdata = CFG_DATA_W'(pad_left);
      REG_PAD_TOP:         prdata = CFG_DATA_W'(pad_top);
      REG_IMAGE_WIDTH:     prdata = CFG_DATA_W'(image_width);
      REG_IMAGE_HEIGHT:    prdata = CFG_DATA_W'(image_height);
      default:             prdata = '0;
    endcase
  end

  // (raw - pad) * inverse_scale, exact
  function automatic prod_t scale_corner(coord_t raw, logic [PAD_W-1:0] pad,
                                         logic [INV_W-1:0] inv);
    logic signed [DIFF_W-1:0] d;
    logic signed [INV_W:0]    k;
    d = DIFF_W'(raw) - DIFF_W'($signed({1'b0, pad, {COORD_FRAC_BITS{1'b0}}}));
    k = $signed({1'b0, inv});
    return PROD_W'(d) * PROD_W'(k);
  endfunction

  // clamp to [0, limit] and round half up to a pixel
  function automatic pix_t to_pixel(prod_t prod, pix_t limit);
    logic [PROD_W-2:0] top;
    logic [PROD_W-2:0] mag;
    logic [PROD_W-2:0] cl;
    logic [PROD_W-2:0] sum;
    top = (PROD_W-1)'(limit) << PIX_SHIFT;
    mag = prod[PROD_W-2:0];
    if (prod[PROD_W-1]) begin
      cl = '0;
    end else if (mag > top) begin
      cl = top;
    end else begin
      cl = mag;
    end
    sum = cl + ((PROD_W-1)'(1) << (PIX_SHIFT - 1));
    return sum[PIX_SHIFT +: PIX_W];
  endfunction

  // handshake chain
  logic out_valid;
  logic s1_valid;
  logic s2_valid;
  logic out_free;
  logic s2_free;
  logic s1_free;
  logic in_take;
  logic s2_go;

  assign out_free     = !out_valid || box_out.ready;
  assign s2_free      = !s2_valid || out_free;
  assign s1_free      = !s1_valid || s2_free;
  assign box_in.ready = s1_free;
  assign in_take      = box_in.valid && s1_free;
  assign s2_go        = s2_valid && out_free;

  // input register
  coord_t s1_x1, s1_y1, s1_x2, s1_y2;
  score_t s1_score;
  class_t s1_class;
  logic   s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= box_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_x1    <= box_in.raw_x1;
      s1_y1    <= box_in.raw_y1;
      s1_x2    <= box_in.raw_x2;
      s1_y2    <= box_in.raw_y2;
      s1_score <= box_in.score_in;
      s1_class <= box_in.class_in;
      s1_last  <= box_in.last_box;
    end
  end

  // product register
  prod_t  s2_px1, s2_py1, s2_px2, s2_py2;
  score_t s2_score;
  class_t s2_class;
  logic   s2_last;
  logic   s2_score_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_free) begin
      s2_px1      <= scale_corner(s1_x1, pad_left, inverse_scale);
      s2_py1      <= scale_corner(s1_y1, pad_top, inverse_scale);
      s2_px2      <= scale_corner(s1_x2, pad_left, inverse_scale);
      s2_py2      <= scale_corner(s1_y2, pad_top, inverse_scale);
      s2_score    <= s1_score;
      s2_class    <= s1_class;
      s2_last     <= s1_last;
      s2_score_ok <= s1_score >= score_threshold;
    end
  end

  // clamp, round, order and keep decision
  pix_t   xa, ya, xb, yb;
  pix_t   x_lo, x_hi, y_lo, y_hi;
  count_t limit_eff;
  count_t kept_count;
  count_t kept_count_next;
  count_t total;
  logic   kept;

  always_comb begin
    xa   = to_pixel(s2_px1, image_width);
    ya   = to_pixel(s2_py1, image_height);
    xb   = to_pixel(s2_px2, image_width);
    yb   = to_pixel(s2_py2, image_height);
    x_lo = (xa > xb) ? xb : xa;
    x_hi = (xa > xb) ? xa : xb;
    y_lo = (ya > yb) ? yb : ya;
    y_hi = (ya > yb) ? ya : yb;
    limit_eff = (detection_limit > COUNT_W'(MAX_KEPT)) ? COUNT_W'(MAX_KEPT)
                                                       : detection_limit;
    kept  = (kept_count < limit_eff) && s2_score_ok && (x_lo != x_hi) && (y_lo != y_hi);
    total = kept ? kept_count + COUNT_W'(1) : kept_count;
    kept_count_next = s2_last ? '0 : total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count <= '0;
    end else if (s2_go) begin
      kept_count <= kept_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s2_valid && (kept || s2_last);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      box_out.box_valid  <= kept;
      box_out.x_left     <= kept ? x_lo : '0;
      box_out.y_top      <= kept ? y_lo : '0;
      box_out.x_right    <= kept ? x_hi : '0;
      box_out.y_bottom   <= kept ? y_hi : '0;
      box_out.score_out  <= kept ? s2_score : '0;
      box_out.class_out  <= kept ? s2_class : '0;
      box_out.frame_done <= s2_last;
      box_out.kept_total <= total;
    end
  end

  assign box_out.valid = out_valid;

endmodule

`default_nettype wire
